### hdl/text_console_cursor_engine_unit_macros.svh
// assertion helpers used by tcce_datapath
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_UNIT_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// plain property, checked every clock outside reset
`define TCCE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("tcce check failed");
// antecedent in this cycle, consequent in the next
`define TCCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcce check failed");
`else
`define TCCE_ASSERT(lbl, clk, rst_n, prop)
`define TCCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### hdl/tcce_pkg.sv
package tcce_pkg;

  localparam int unsigned BUF_LINES    = 72;
  localparam int unsigned LINE_CELLS   = 80;
  localparam int unsigned VIEW_LINES   = 24;
  localparam int unsigned SCROLL_LINES = 24;
  localparam int unsigned TAB_CELLS    = 4;

  localparam int unsigned SCROLL_EFF  = (SCROLL_LINES < BUF_LINES) ? SCROLL_LINES : BUF_LINES;
  localparam int unsigned STORE_CELLS = BUF_LINES * LINE_CELLS;
  localparam int unsigned SHIFT_CELLS = SCROLL_EFF * LINE_CELLS;

  localparam int unsigned ADDR_W = $clog2(STORE_CELLS);
  localparam int unsigned LINE_W = $clog2(BUF_LINES);
  localparam int unsigned COL_W  = $clog2(LINE_CELLS);
  localparam int unsigned RUN_W  = $clog2(LINE_CELLS + 1);
  // top line plus any 5-bit row, times a line, plus any 7-bit column
  localparam int unsigned RD_W   = $clog2((BUF_LINES + 32) * LINE_CELLS + 128);

  // transaction field widths
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned VROW_W = 5;
  localparam int unsigned VCOL_W = 7;
  localparam int unsigned OLINE_W = 7;
  localparam int unsigned OCOL_W  = 7;
  localparam int unsigned OTOP_W  = 6;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_VT  = 8'h0B;
  localparam logic [CHAR_W-1:0] CH_FF  = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLEAR,
    OP_SCROLL,
    OP_COPY,
    OP_RUN,
    OP_CR,
    OP_BS,
    OP_RD_ADDR,
    OP_RD_MEM,
    OP_DONE
  } dp_op_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DISPATCH,
    ST_COPY,
    ST_TAIL,
    ST_RUN,
    ST_RD_MEM,
    ST_DONE
  } ctl_state_e;

  typedef struct packed {
    dp_op_e op;
  } tcce_cmd_t;

  typedef struct packed {
    logic is_read;
    logic is_cr;
    logic is_bs;
    logic need_scroll;
    logic copy_last;
    logic clear_last;
    logic run_last;
    logic out_free;
  } tcce_sts_t;

endpackage

### hdl/tcce_ctrl.sv
module tcce_ctrl import tcce_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  tcce_sts_t sts_i,
  output tcce_cmd_t cmd_o
);

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_INIT: begin
        // clear the whole store once after reset
        cmd_o.op = OP_CLEAR;
        if (sts_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        priority if (sts_i.is_read) begin
          cmd_o.op = OP_RD_ADDR;
          state_d  = ST_RD_MEM;
        end else if (sts_i.is_cr) begin
          cmd_o.op = OP_CR;
          state_d  = ST_DONE;
        end else if (sts_i.is_bs) begin
          cmd_o.op = OP_BS;
          state_d  = ST_DONE;
        end else if (sts_i.need_scroll) begin
          cmd_o.op = OP_SCROLL;
          state_d  = ST_COPY;
        end else begin
          // first cell of the run goes out straight away
          cmd_o.op = OP_RUN;
          state_d  = sts_i.run_last ? ST_DONE : ST_RUN;
        end
      end
      ST_COPY: begin
        cmd_o.op = OP_COPY;
        if (sts_i.copy_last) state_d = ST_TAIL;
      end
      ST_TAIL: begin
        cmd_o.op = OP_CLEAR;
        if (sts_i.clear_last) state_d = ST_RUN;
      end
      ST_RUN: begin
        cmd_o.op = OP_RUN;
        if (sts_i.run_last) state_d = ST_DONE;
      end
      ST_RD_MEM: begin
        cmd_o.op = OP_RD_MEM;
        state_d  = ST_DONE;
      end
      ST_DONE: begin
        cmd_o.op = OP_DONE;
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

endmodule

### hdl/tcce_datapath.sv
`include "text_console_cursor_engine_unit_macros.svh"

module tcce_datapath import tcce_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tcce_cmd_t         cmd_i,
  output tcce_sts_t         sts_o,
  input  logic              command_i,
  input  logic [CHAR_W-1:0] char_code_i,
  input  logic [VROW_W-1:0] view_row_i,
  input  logic [VCOL_W-1:0] view_col_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CHAR_W-1:0] cell_char_o,
  output logic [OLINE_W-1:0] cursor_line_o,
  output logic [OCOL_W-1:0] cursor_col_o,
  output logic [OTOP_W-1:0] view_top_line_o,
  output logic              scrolled_o
);

  logic [CHAR_W-1:0] mem [STORE_CELLS];

  // control state
  logic [ADDR_W-1:0] pos_q, pos_d;
  logic [LINE_W-1:0] line_q, line_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ADDR_W-1:0] cnt_q, cnt_d;
  logic [RUN_W-1:0]  run_left_q, run_left_d;
  logic              scrolled_q, scrolled_d;
  logic              out_valid_q, out_valid_d;

  // item and read path payload
  logic              item_cmd_q;
  logic [CHAR_W-1:0] item_char_q;
  logic [CHAR_W-1:0] run_char_q;
  logic [VROW_W-1:0] vrow_q;
  logic [VCOL_W-1:0] vcol_q;
  logic [RD_W-1:0]   rd_pos_q;
  logic              rd_inrange_q;
  logic              rd_ok_q;
  logic [CHAR_W-1:0] rdata_q;

  logic [CHAR_W-1:0]  cell_char_q;
  logic [OLINE_W-1:0] cursor_line_q;
  logic [OCOL_W-1:0]  cursor_col_q;
  logic [OTOP_W-1:0]  view_top_q;
  logic               scrolled_out_q;

  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [CHAR_W-1:0] mem_wdata;

  logic [LINE_W:0]   lines_used;
  logic [LINE_W-1:0] view_top;
  logic [RD_W-1:0]   rd_pos;
  logic              rd_inrange;
  logic              rd_ok;
  logic [RUN_W-1:0]  load_run;
  logic [CHAR_W-1:0] load_char;
  logic              out_free;

  // view ends at the line holding the cursor, rounded up
  always_comb begin
    lines_used = (LINE_W + 1)'(line_q) + (LINE_W + 1)'(col_q != '0);
    if (32'(lines_used) > VIEW_LINES) begin
      view_top = LINE_W'(32'(lines_used) - VIEW_LINES);
    end else begin
      view_top = '0;
    end
  end

  assign rd_pos = (RD_W'(view_top) + RD_W'(vrow_q)) * RD_W'(LINE_CELLS) + RD_W'(vcol_q);
  assign rd_inrange = (32'(vrow_q) < VIEW_LINES) && (32'(vcol_q) < LINE_CELLS);
  assign rd_ok = rd_inrange_q && (rd_pos_q < RD_W'(STORE_CELLS))
                 && (rd_pos_q <= RD_W'(pos_q));

  always_comb begin
    load_char = '0;
    unique case (char_code_i)
      CH_LF, CH_FF: load_run = RUN_W'(LINE_CELLS) - RUN_W'(col_q);
      CH_VT:        load_run = RUN_W'(LINE_CELLS);
      CH_TAB:       load_run = RUN_W'(TAB_CELLS);
      default: begin
        load_run  = RUN_W'(1);
        load_char = char_code_i;
      end
    endcase
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    sts_o.is_read     = (item_cmd_q == CMD_READ);
    sts_o.is_cr       = (item_cmd_q == CMD_WRITE) && (item_char_q == CH_CR);
    sts_o.is_bs       = (item_cmd_q == CMD_WRITE) && (item_char_q == CH_BS);
    sts_o.need_scroll = ((ADDR_W + 1)'(pos_q) + (ADDR_W + 1)'(run_left_q))
                        >= (ADDR_W + 1)'(STORE_CELLS);
    sts_o.copy_last   = (cnt_q == pos_q);
    sts_o.clear_last  = (cnt_q == ADDR_W'(STORE_CELLS - 1));
    sts_o.run_last    = (run_left_q == RUN_W'(1));
    sts_o.out_free    = out_free;
  end

  always_comb begin
    pos_d       = pos_q;
    line_d      = line_q;
    col_d       = col_q;
    cnt_d       = cnt_q;
    run_left_d  = run_left_q;
    scrolled_d  = scrolled_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_we      = 1'b0;
    mem_waddr   = pos_q;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = cnt_q;
    unique case (cmd_i.op)
      OP_LOAD: begin
        run_left_d = load_run;
        scrolled_d = 1'b0;
      end
      OP_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q;
        cnt_d     = cnt_q + 1'b1;
      end
      OP_SCROLL: begin
        // whole lines move, so the column survives unless the cursor falls off
        if (32'(line_q) >= SCROLL_EFF) begin
          line_d = line_q - LINE_W'(SCROLL_EFF);
          pos_d  = pos_q - ADDR_W'(SHIFT_CELLS);
        end else begin
          line_d = '0;
          col_d  = '0;
          pos_d  = '0;
        end
        cnt_d      = '0;
        scrolled_d = 1'b1;
      end
      OP_COPY: begin
        // read one cell ahead, write the cell fetched in the cycle before
        mem_re    = !sts_o.copy_last;
        mem_raddr = cnt_q + ADDR_W'(SHIFT_CELLS);
        mem_we    = (cnt_q != '0);
        mem_waddr = cnt_q - 1'b1;
        mem_wdata = rdata_q;
        if (!sts_o.copy_last) cnt_d = cnt_q + 1'b1;
      end
      OP_RUN: begin
        mem_we     = 1'b1;
        mem_wdata  = run_char_q;
        pos_d      = pos_q + 1'b1;
        run_left_d = run_left_q - 1'b1;
        if (col_q == COL_W'(LINE_CELLS - 1)) begin
          col_d  = '0;
          line_d = line_q + 1'b1;
        end else begin
          col_d = col_q + 1'b1;
        end
      end
      OP_CR: begin
        pos_d = pos_q - ADDR_W'(col_q);
        col_d = '0;
      end
      OP_BS: begin
        if (pos_q != '0) begin
          pos_d     = pos_q - 1'b1;
          mem_we    = 1'b1;
          mem_waddr = pos_q - 1'b1;
          if (col_q == '0) begin
            col_d  = COL_W'(LINE_CELLS - 1);
            line_d = line_q - 1'b1;
          end else begin
            col_d = col_q - 1'b1;
          end
        end
      end
      OP_RD_MEM: begin
        mem_re    = rd_ok;
        mem_raddr = rd_pos_q[ADDR_W-1:0];
      end
      OP_DONE: begin
        if (out_free) out_valid_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      line_q      <= '0;
      col_q       <= '0;
      cnt_q       <= '0;
      run_left_q  <= '0;
      scrolled_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      line_q      <= line_d;
      col_q       <= col_d;
      cnt_q       <= cnt_d;
      run_left_q  <= run_left_d;
      scrolled_q  <= scrolled_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      item_cmd_q  <= command_i;
      item_char_q <= char_code_i;
      run_char_q  <= load_char;
      vrow_q      <= view_row_i;
      vcol_q      <= view_col_i;
    end
    if (cmd_i.op == OP_RD_ADDR) begin
      rd_pos_q     <= rd_pos;
      rd_inrange_q <= rd_inrange;
    end
    if (cmd_i.op == OP_RD_MEM) begin
      rd_ok_q <= rd_ok;
    end
    if ((cmd_i.op == OP_DONE) && out_free) begin
      cell_char_q    <= ((item_cmd_q == CMD_READ) && rd_ok_q) ? rdata_q : '0;
      cursor_line_q  <= OLINE_W'(line_q);
      cursor_col_q   <= OCOL_W'(col_q);
      view_top_q     <= OTOP_W'(view_top);
      scrolled_out_q <= scrolled_q;
    end
  end

  // cell store, one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) rdata_q <= mem[mem_raddr];
  end

  assign out_valid_o     = out_valid_q;
  assign cell_char_o     = cell_char_q;
  assign cursor_line_o   = cursor_line_q;
  assign cursor_col_o    = cursor_col_q;
  assign view_top_line_o = view_top_q;
  assign scrolled_o      = scrolled_out_q;

  `TCCE_ASSERT(a_cursor_split, clk_i, rst_ni, 32'(pos_q) == 32'(line_q) * LINE_CELLS + 32'(col_q))
  `TCCE_ASSERT(a_run_in_store, clk_i, rst_ni, (cmd_i.op != OP_RUN) || (32'(pos_q) < STORE_CELLS - 1))
  `TCCE_ASSERT_NEXT(a_load_clears_scroll, clk_i, rst_ni, cmd_i.op == OP_LOAD, !scrolled_q)
  `TCCE_ASSERT(a_read_no_scroll, clk_i, rst_ni, (cmd_i.op != OP_RD_MEM) || !scrolled_q)

endmodule

### hdl/text_console_cursor_engine_unit.sv
// Text console with a 72-line by 80-cell character store and a write cursor. Each
// transaction either writes one byte (control codes clear cells or move the cursor)
// or reads one cell of the 24-line view that ends at the cursor's line; every
// transaction gives exactly one result. The store has a single write port, so
// cells are touched one a cycle: a blank run (newline, form feed, vertical tab,
// tab) writes its n cleared cells one after another, and a transaction that has
// to scroll first moves the kept lines up and clears the cells after them. After
// reset the store is cleared one cell a cycle, with in_stall_o held high. A
// finished result waits in an output register; the next transaction is taken
// while it is still there.
module text_console_cursor_engine_unit import tcce_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               command_i,
  input  logic [CHAR_W-1:0]  char_code_i,
  input  logic [VROW_W-1:0]  view_row_i,
  input  logic [VCOL_W-1:0]  view_col_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [CHAR_W-1:0]  cell_char_o,
  output logic [OLINE_W-1:0] cursor_line_o,
  output logic [OCOL_W-1:0]  cursor_col_o,
  output logic [OTOP_W-1:0]  view_top_line_o,
  output logic               scrolled_o
);

  tcce_cmd_t cmd;
  tcce_sts_t sts;

  tcce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tcce_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .command_i       (command_i),
    .char_code_i     (char_code_i),
    .view_row_i      (view_row_i),
    .view_col_i      (view_col_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .cell_char_o     (cell_char_o),
    .cursor_line_o   (cursor_line_o),
    .cursor_col_o    (cursor_col_o),
    .view_top_line_o (view_top_line_o),
    .scrolled_o      (scrolled_o)
  );

endmodule
